// ===== rtl/utf8s_pkg.sv =====
// utf8s_pkg: item types, the decoded command format and the replacement bytes
// shared by the UTF-8 sanitizer modules. No dependencies.
package utf8s_pkg;

  // Input item: one raw byte of the text
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_item_t;

  // Result item: one byte of sanitized output
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_text_end;
  } out_item_t;

  // Decoded command: n_rep replacement triples, then n_lit literal bytes
  typedef struct packed {
    logic [2:0]      n_rep;
    logic [2:0]      n_lit;
    logic [3:0][7:0] lit;        // lit[0] goes out first
    logic            final_flag;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_2  = 21'h000080;
  localparam logic [20:0] CP_MIN_3  = 21'h000800;
  localparam logic [20:0] CP_MIN_4  = 21'h010000;

endpackage

// ===== rtl/utf8s_front.sv =====
// utf8s_front: accepts raw bytes, tracks the open sequence and decodes each
// byte into at most one output command. Depends on utf8s_pkg.
module utf8s_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  utf8s_pkg::in_item_t  in_item_i,
  output logic                 cmd_valid_o,
  output utf8s_pkg::cmd_t      cmd_o
);

  logic [2:0]  seq_len_q, seq_len_d;
  logic [7:0]  lead_q, lead_d;
  logic [7:0]  conts_q [2];
  logic [7:0]  conts_d [2];
  logic [1:0]  cnt_q, cnt_d;
  logic [20:0] acc_q, acc_d;

  logic [7:0]  b;
  logic        fin;
  logic        seq_open;
  logic        is_cont;
  logic        complete;
  logic [20:0] cp;
  logic [20:0] cp_min;
  logic        cp_bad;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;
  logic        do_start;
  utf8s_pkg::cmd_t cmd;

  assign b        = in_item_i.in_byte;
  assign fin      = in_item_i.in_final;
  assign seq_open = (seq_len_q != 3'd0);
  assign is_cont  = (b[7:6] == 2'b10);
  assign complete = (({1'b0, cnt_q} + 3'd2) == seq_len_q);
  assign cp       = {acc_q[14:0], b[5:0]};

  always_comb begin
    unique case (seq_len_q)
      3'd2:    cp_min = utf8s_pkg::CP_MIN_2;
      3'd3:    cp_min = utf8s_pkg::CP_MIN_3;
      default: cp_min = utf8s_pkg::CP_MIN_4;
    endcase
  end

  assign cp_bad = (cp < cp_min) || (cp > utf8s_pkg::CP_MAX) ||
                  ((cp >= utf8s_pkg::SURR_LO) && (cp <= utf8s_pkg::SURR_HI));

  // Lead byte class and its payload bits
  always_comb begin
    lead_len  = 3'd0;
    lead_bits = '0;
    if (b[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.final_flag = fin;
    seq_len_d      = seq_len_q;
    lead_d         = lead_q;
    conts_d        = conts_q;
    cnt_d          = cnt_q;
    acc_d          = acc_q;
    do_start       = 1'b0;

    if (!seq_open) begin
      do_start = 1'b1;
    end else if (!is_cont) begin
      // broken sequence: replace lead and held bytes, then restart on b
      cmd.n_rep = 3'd1 + {1'b0, cnt_q};
      seq_len_d = 3'd0;
      cnt_d     = 2'd0;
      do_start  = 1'b1;
    end else if (complete) begin
      if (cp_bad) begin
        cmd.n_rep = {1'b0, cnt_q} + 3'd2;
      end else begin
        cmd.n_lit  = {1'b0, cnt_q} + 3'd2;
        cmd.lit[0] = lead_q;
        cmd.lit[1] = (cnt_q != 2'd0) ? conts_q[0] : b;
        cmd.lit[2] = (cnt_q == 2'd2) ? conts_q[1] : b;
        cmd.lit[3] = b;
      end
      seq_len_d = 3'd0;
      cnt_d     = 2'd0;
    end else if (fin) begin
      // cut off by end of text
      cmd.n_rep = {1'b0, cnt_q} + 3'd2;
      seq_len_d = 3'd0;
      cnt_d     = 2'd0;
    end else begin
      conts_d[cnt_q[0]] = b;
      cnt_d             = cnt_q + 2'd1;
      acc_d             = cp;
    end

    if (do_start) begin
      if (!b[7]) begin
        cmd.n_lit  = 3'd1;
        cmd.lit[0] = b;
      end else if ((lead_len != 3'd0) && !fin) begin
        seq_len_d = lead_len;
        lead_d    = b;
        cnt_d     = 2'd0;
        acc_d     = lead_bits;
      end else begin
        cmd.n_rep = cmd.n_rep + 3'd1;
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && ((cmd.n_rep != 3'd0) || (cmd.n_lit != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= 3'd0;
      cnt_q     <= 2'd0;
    end else if (accept_i) begin
      seq_len_q <= seq_len_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      lead_q  <= lead_d;
      conts_q <= conts_d;
      acc_q   <= acc_d;
    end
  end

  // an open sequence never already holds all of its bytes
  a_open_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_open |-> (({1'b0, cnt_q} + 3'd2) <= seq_len_q))
    else $error("open sequence holds too many continuation bytes");

  // a final byte always leaves the sequence closed
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && fin) |=> (seq_len_q == 3'd0))
    else $error("sequence left open after final byte");

endmodule

// ===== rtl/utf8s_queue.sv =====
// utf8s_queue: small register queue of decoded commands between the front
// and back parts. Depends on utf8s_pkg.
module utf8s_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  utf8s_pkg::cmd_t    wr_data_i,
  input  logic               rd_i,
  output utf8s_pkg::cmd_t    rd_data_o,
  output utf8s_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utf8s_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_wr, do_rd;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !stat_o.full)
    else $error("command written into full queue");

endmodule

// ===== rtl/utf8s_back.sv =====
// utf8s_back: expands decoded commands into output bytes, one per cycle while
// pop is high, replacement triples first, then literal bytes. Depends on utf8s_pkg.
module utf8s_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8s_pkg::cmd_t      cmd_i,
  input  utf8s_pkg::q_stat_t   q_stat_i,
  output logic                 q_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output utf8s_pkg::out_item_t out_item_o
);

  logic            busy_q;
  logic [2:0]      rep_left_q;
  logic [1:0]      phase_q;
  logic [2:0]      lit_left_q;
  logic [3:0][7:0] sh_q;
  logic            final_q;

  logic            last;
  logic            take;
  logic            load;
  logic [7:0]      cur_byte;

  assign empty_o = !busy_q;
  assign take    = pop_i && busy_q;

  assign last = ((rep_left_q == 3'd1) && (phase_q == 2'd2) && (lit_left_q == 3'd0)) ||
                ((rep_left_q == 3'd0) && (lit_left_q == 3'd1));

  // refill from the queue when idle or when the last byte goes out
  assign load   = !busy_q || (take && last);
  assign q_rd_o = load && !q_stat_i.empty;

  always_comb begin
    if (rep_left_q != 3'd0) begin
      case (phase_q)
        2'd0:    cur_byte = utf8s_pkg::REPL_B0;
        2'd1:    cur_byte = utf8s_pkg::REPL_B1;
        default: cur_byte = utf8s_pkg::REPL_B2;
      endcase
    end else begin
      cur_byte = sh_q[0];
    end
  end

  assign out_item_o.out_byte     = cur_byte;
  assign out_item_o.out_run_last = last;
  assign out_item_o.out_text_end = last && final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rep_left_q <= 3'd0;
      phase_q    <= 2'd0;
      lit_left_q <= 3'd0;
    end else if (load) begin
      busy_q     <= !q_stat_i.empty;
      rep_left_q <= q_stat_i.empty ? 3'd0 : cmd_i.n_rep;
      phase_q    <= 2'd0;
      lit_left_q <= q_stat_i.empty ? 3'd0 : cmd_i.n_lit;
    end else if (take) begin
      if (rep_left_q != 3'd0) begin
        if (phase_q == 2'd2) begin
          phase_q    <= 2'd0;
          rep_left_q <= rep_left_q - 3'd1;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end else begin
        lit_left_q <= lit_left_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q    <= cmd_i.lit;
      final_q <= cmd_i.final_flag;
    end else if (take && (rep_left_q == 3'd0)) begin
      sh_q <= {8'd0, sh_q[3:1]};
    end
  end

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((rep_left_q != 3'd0) || (lit_left_q != 3'd0)))
    else $error("busy with nothing left to send");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("replacement phase out of range");

endmodule

// ===== rtl/utf8_sanitizer.sv =====
// utf8_sanitizer: top level of the streaming UTF-8 sanitizer; ties the
// decoding front, the command queue and the output back together.
// Depends on utf8s_pkg, utf8s_front, utf8s_queue, utf8s_back.
//
//   channel   handshake            payload        direction
//   input     push / full          in_item_i      into block
//   result    empty / pop          out_item_o     out of block
//
// The front decodes one byte per cycle while not full and writes at most one
// command; the back sends one output byte per cycle while pop is high, so a
// command of N bytes (1 for ASCII, up to 12 for four replacements) holds the
// back until all are popped. The input sees full only when the command queue
// of QUEUE_DEPTH entries is full; plain ASCII flows at one byte per cycle
// with pop held high. Reset clears the open sequence, the queue and the
// output stage. A held result does not block the front until the queue fills.
module utf8_sanitizer #(
  parameter int unsigned QUEUE_DEPTH = 2  // commands between front and back, 2..16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  utf8s_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output utf8s_pkg::out_item_t out_item_o
);

  utf8s_pkg::cmd_t    fr_cmd;
  logic               fr_cmd_valid;
  utf8s_pkg::cmd_t    q_head;
  utf8s_pkg::q_stat_t q_stat;
  logic               q_rd;
  logic               accept;

  // Any accepted byte may produce a command, so accept only with queue room.
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  utf8s_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cmd_valid_o (fr_cmd_valid),
    .cmd_o       (fr_cmd)
  );

  utf8s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_cmd_valid),
    .wr_data_i (fr_cmd),
    .rd_i      (q_rd),
    .rd_data_o (q_head),
    .stat_o    (q_stat)
  );

  // Back: output byte registers, presented while empty is low.
  utf8s_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_head),
    .q_stat_i   (q_stat),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
